@@ hdl/rgbg_pkg.sv @@
// Shared types and constants for the RGB to gray blend core.
// No dependencies; imported by every module of the core.
package rgbg_pkg;

   localparam int CHANNEL_BITS = 8;
   localparam logic [CHANNEL_BITS-1:0] CHMAX = '1;

   localparam int PIX_BITS   = 4 * CHANNEL_BITS;
   localparam int TDATA_BITS = ((PIX_BITS + 7) / 8) * 8;

   localparam int MODE_BITS     = 3;
   localparam int BLEND_BITS    = 9;
   localparam int CSR_ADDR_BITS = 1;
   localparam int CSR_DATA_BITS = BLEND_BITS;

   localparam logic [CSR_ADDR_BITS-1:0] CSR_MODE_SEL = 1'd0;
   localparam logic [CSR_ADDR_BITS-1:0] CSR_BLEND_Q8 = 1'd1;

   localparam logic [MODE_BITS-1:0] MODE_LUMA      = 3'd0;
   localparam logic [MODE_BITS-1:0] MODE_LIGHTNESS = 3'd1;
   localparam logic [MODE_BITS-1:0] MODE_AVERAGE   = 3'd2;
   localparam logic [MODE_BITS-1:0] MODE_RED       = 3'd3;
   localparam logic [MODE_BITS-1:0] MODE_GREEN     = 3'd4;
   localparam logic [MODE_BITS-1:0] MODE_BLUE      = 3'd5;
   localparam logic [MODE_BITS-1:0] MODE_MAX       = 3'd6;

   localparam logic [BLEND_BITS-1:0] BLEND_ONE  = 9'd256;
   localparam int                    BLEND_FRAC = 8;
   localparam int                    BLEND_HALF = 128;

   // luma weights, Q16
   localparam int W_RED   = 19589;
   localparam int W_GREEN = 38443;
   localparam int W_BLUE  = 7503;
   localparam int LUMA_FRAC   = 16;
   localparam int LUMA_R_BITS = CHANNEL_BITS + 15;
   localparam int LUMA_G_BITS = CHANNEL_BITS + 16;
   localparam int LUMA_B_BITS = CHANNEL_BITS + 13;
   localparam int LUMA_BITS   = CHANNEL_BITS + LUMA_FRAC;

   // divide by three: floor(x * ceil(2^k/3) / 2^k), exact for x < 2^(k-1)
   localparam int SUM3_BITS  = CHANNEL_BITS + 2;
   localparam int DIV3_SHIFT = SUM3_BITS + 1;
   localparam int DIV3_MUL   = ((1 << DIV3_SHIFT) + 2) / 3;
   localparam int DIV3_BITS  = SUM3_BITS + DIV3_SHIFT;

   localparam int MIX_PROD_BITS = CHANNEL_BITS + BLEND_BITS;
   localparam int MIX_SUM_BITS  = MIX_PROD_BITS + 1;

   typedef struct packed {
      logic [CHANNEL_BITS-1:0] alpha;
      logic [CHANNEL_BITS-1:0] blue;
      logic [CHANNEL_BITS-1:0] green;
      logic [CHANNEL_BITS-1:0] red;
   } pix_type;

   typedef struct packed {
      logic [LUMA_R_BITS-1:0]  prod_r;
      logic [LUMA_G_BITS-1:0]  prod_g;
      logic [LUMA_B_BITS-1:0]  prod_b;
      logic [CHANNEL_BITS-1:0] max_c;
      logic [CHANNEL_BITS-1:0] min_c;
      logic [SUM3_BITS-1:0]    sum3;
      pix_type                 pix;
   } gray_s1_type;

   typedef struct packed {
      logic [CHANNEL_BITS-1:0] gray;
      pix_type                 pix;
   } gray_pix_type;

   typedef struct packed {
      logic [MIX_PROD_BITS-1:0] prod_r;
      logic [MIX_PROD_BITS-1:0] prod_g;
      logic [MIX_PROD_BITS-1:0] prod_b;
      logic [MIX_PROD_BITS-1:0] prod_gray;
      logic [CHANNEL_BITS-1:0]  alpha;
   } mix_s3_type;

endpackage

@@ hdl/rgbg_gray.sv @@
// Gray level stages: weighted products, extremes and channel sum, then mode select.
// Depends on rgbg_pkg.
module rgbg_gray (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              adv,
   input  logic                              in_valid,
   input  rgbg_pkg::pix_type                 in_pix,
   input  logic [rgbg_pkg::MODE_BITS-1:0]    mode_sel,
   output logic                              out_valid,
   output rgbg_pkg::gray_pix_type            out_item
);
   import rgbg_pkg::*;

   logic                    s1_valid_ff;
   gray_s1_type             s1_ff;
   gray_s1_type             s1_in;
   logic                    s2_valid_ff;
   gray_pix_type            s2_ff;
   gray_pix_type            s2_in;
   logic [CHANNEL_BITS-1:0] max_rg;
   logic [CHANNEL_BITS-1:0] min_rg;
   logic [LUMA_BITS-1:0]    luma_sum;
   logic [CHANNEL_BITS:0]   light_sum;
   logic [DIV3_BITS-1:0]    avg_prod;

   always_comb begin
      max_rg = (in_pix.red > in_pix.green) ? in_pix.red : in_pix.green;
      min_rg = (in_pix.red < in_pix.green) ? in_pix.red : in_pix.green;
      s1_in.max_c  = (max_rg > in_pix.blue) ? max_rg : in_pix.blue;
      s1_in.min_c  = (min_rg < in_pix.blue) ? min_rg : in_pix.blue;
      s1_in.prod_r = LUMA_R_BITS'(in_pix.red) * LUMA_R_BITS'(W_RED);
      s1_in.prod_g = LUMA_G_BITS'(in_pix.green) * LUMA_G_BITS'(W_GREEN);
      s1_in.prod_b = LUMA_B_BITS'(in_pix.blue) * LUMA_B_BITS'(W_BLUE);
      s1_in.sum3   = SUM3_BITS'(in_pix.red) + SUM3_BITS'(in_pix.green)
                   + SUM3_BITS'(in_pix.blue);
      s1_in.pix    = in_pix;
   end

   always_comb begin
      luma_sum  = LUMA_BITS'(s1_ff.prod_r) + LUMA_BITS'(s1_ff.prod_g)
                + LUMA_BITS'(s1_ff.prod_b);
      light_sum = (CHANNEL_BITS+1)'(s1_ff.max_c) + (CHANNEL_BITS+1)'(s1_ff.min_c);
      avg_prod  = DIV3_BITS'(s1_ff.sum3) * DIV3_BITS'(DIV3_MUL);
      s2_in.pix = s1_ff.pix;
      unique case (mode_sel)
         MODE_LIGHTNESS: s2_in.gray = light_sum[CHANNEL_BITS:1];
         MODE_AVERAGE:   s2_in.gray = avg_prod[DIV3_SHIFT +: CHANNEL_BITS];
         MODE_RED:       s2_in.gray = s1_ff.pix.red;
         MODE_GREEN:     s2_in.gray = s1_ff.pix.green;
         MODE_BLUE:      s2_in.gray = s1_ff.pix.blue;
         MODE_MAX:       s2_in.gray = s1_ff.max_c;
         default:        s2_in.gray = luma_sum[LUMA_FRAC +: CHANNEL_BITS];
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else if (adv) begin
         s1_valid_ff <= in_valid;
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_ff <= s1_in;
         s2_ff <= s2_in;
      end
   end

   assign out_valid = s2_valid_ff;
   assign out_item  = s2_ff;

endmodule

@@ hdl/rgbg_blend.sv @@
// Blend stages: weight colour and gray by the blend share, then round and hold the result.
// Depends on rgbg_pkg.
module rgbg_blend (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              adv,
   input  logic                              in_valid,
   input  rgbg_pkg::gray_pix_type            in_item,
   input  logic [rgbg_pkg::BLEND_BITS-1:0]   blend_q8,
   output logic                              out_valid,
   output rgbg_pkg::pix_type                 out_pix
);
   import rgbg_pkg::*;

   logic                   s3_valid_ff;
   mix_s3_type             s3_ff;
   mix_s3_type             s3_in;
   logic                   s4_valid_ff;
   pix_type                s4_ff;
   pix_type                s4_in;
   logic [BLEND_BITS-1:0]  keep;
   logic [BLEND_BITS-1:0]  drop;
   logic [MIX_SUM_BITS-1:0] sum_r;
   logic [MIX_SUM_BITS-1:0] sum_g;
   logic [MIX_SUM_BITS-1:0] sum_b;

   always_comb begin
      keep = (blend_q8 > BLEND_ONE) ? BLEND_ONE : blend_q8;
      drop = BLEND_ONE - keep;
      s3_in.prod_r    = MIX_PROD_BITS'(in_item.pix.red) * MIX_PROD_BITS'(keep);
      s3_in.prod_g    = MIX_PROD_BITS'(in_item.pix.green) * MIX_PROD_BITS'(keep);
      s3_in.prod_b    = MIX_PROD_BITS'(in_item.pix.blue) * MIX_PROD_BITS'(keep);
      s3_in.prod_gray = MIX_PROD_BITS'(in_item.gray) * MIX_PROD_BITS'(drop);
      s3_in.alpha     = in_item.pix.alpha;
   end

   always_comb begin
      sum_r = MIX_SUM_BITS'(s3_ff.prod_r) + MIX_SUM_BITS'(s3_ff.prod_gray)
            + MIX_SUM_BITS'(BLEND_HALF);
      sum_g = MIX_SUM_BITS'(s3_ff.prod_g) + MIX_SUM_BITS'(s3_ff.prod_gray)
            + MIX_SUM_BITS'(BLEND_HALF);
      sum_b = MIX_SUM_BITS'(s3_ff.prod_b) + MIX_SUM_BITS'(s3_ff.prod_gray)
            + MIX_SUM_BITS'(BLEND_HALF);
      s4_in.red   = sum_r[BLEND_FRAC +: CHANNEL_BITS];
      s4_in.green = sum_g[BLEND_FRAC +: CHANNEL_BITS];
      s4_in.blue  = sum_b[BLEND_FRAC +: CHANNEL_BITS];
      s4_in.alpha = s3_ff.alpha;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
      end else if (adv) begin
         s3_valid_ff <= in_valid;
         s4_valid_ff <= s3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s3_ff <= s3_in;
         s4_ff <= s4_in;
      end
   end

   assign out_valid = s4_valid_ff;
   assign out_pix   = s4_ff;

endmodule

@@ hdl/rgb_to_gray_blend_core.sv @@
// Top level of the RGB to gray blend core: stream ports, register file, stage hookup.
// Depends on rgbg_pkg, rgbg_gray and rgbg_blend.
//
// Usage:
//   req_* takes one RGBA pixel per item, rsp_* gives one blended pixel per item,
//   in the same order. csr_* writes the gray mode (index 0) and blend_q8 (index 1);
//   write them only while no item is in flight.
//   From acceptance to rsp_tvalid an item passes four registered stages: weighted products,
//   gray select, blend products, round into the output register.
//   Throughput is one item per cycle unless rsp_tready stalls; the four stages advance together.
//   When rsp_tready is low with a result held, all stages hold and req_tready
//   drops; nothing is lost or repeated. Bubbles in the pipe hold as well.
//   Reset (synchronous) clears all stage valid bits, the gray mode to luma and
//   blend_q8 to zero (pure gray).
module rgb_to_gray_blend_core (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   // red, green, blue, alpha from bit 0 up, zero filled to whole bytes
   input  logic [rgbg_pkg::TDATA_BITS-1:0]       req_tdata,
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   // red, green, blue, alpha from bit 0 up, zero filled to whole bytes
   output logic [rgbg_pkg::TDATA_BITS-1:0]       rsp_tdata,
   input  logic                                  csr_we,
   input  logic [rgbg_pkg::CSR_ADDR_BITS-1:0]    csr_addr,
   input  logic [rgbg_pkg::CSR_DATA_BITS-1:0]    csr_wdata
);
   import rgbg_pkg::*;

   logic [MODE_BITS-1:0]  mode_sel_ff;
   logic [MODE_BITS-1:0]  mode_sel_in;
   logic [BLEND_BITS-1:0] blend_ff;
   logic [BLEND_BITS-1:0] blend_in;
   logic                  adv;
   logic                  gray_valid;
   gray_pix_type          gray_item;
   pix_type               in_pix;
   pix_type               out_pix;
   logic                  out_valid;

   always_comb begin
      mode_sel_in = mode_sel_ff;
      blend_in    = blend_ff;
      if (csr_we) begin
         unique case (csr_addr)
            CSR_MODE_SEL: mode_sel_in = csr_wdata[MODE_BITS-1:0];
            CSR_BLEND_Q8: blend_in    = csr_wdata[BLEND_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_sel_ff <= MODE_LUMA;
         blend_ff    <= '0;
      end else begin
         mode_sel_ff <= mode_sel_in;
         blend_ff    <= blend_in;
      end
   end

   assign adv        = !out_valid || rsp_tready;
   assign req_tready = adv;
   assign in_pix     = req_tdata[PIX_BITS-1:0];

   rgbg_gray u_gray (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (req_tvalid),
      .in_pix    (in_pix),
      .mode_sel  (mode_sel_ff),
      .out_valid (gray_valid),
      .out_item  (gray_item)
   );

   rgbg_blend u_blend (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (gray_valid),
      .in_item   (gray_item),
      .blend_q8  (blend_ff),
      .out_valid (out_valid),
      .out_pix   (out_pix)
   );

   assign rsp_tvalid = out_valid;
   assign rsp_tdata  = TDATA_BITS'(out_pix);

`ifndef ASSERT_OFF
   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("input stalled with empty output register");

   a_alpha_through: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && $past(req_tvalid && req_tready, 4) && $past(adv, 1)
         && $past(adv, 2) && $past(adv, 3) && !$past(reset, 1) && !$past(reset, 2)
         && !$past(reset, 3) && !$past(reset, 4)
      |-> rsp_tdata[PIX_BITS-1 -: CHANNEL_BITS]
          == $past(req_tdata[PIX_BITS-1 -: CHANNEL_BITS], 4))
      else $error("alpha changed on its way through");

   a_full_blend_through: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && $past(req_tvalid && req_tready, 4) && $past(adv, 1)
         && $past(adv, 2) && $past(adv, 3) && !$past(reset, 1) && !$past(reset, 2)
         && !$past(reset, 3) && !$past(reset, 4)
         && !$past(csr_we, 1) && !$past(csr_we, 2) && !$past(csr_we, 3)
         && !$past(csr_we, 4) && (blend_ff >= BLEND_ONE)
      |-> rsp_tdata[PIX_BITS-1:0] == $past(req_tdata[PIX_BITS-1:0], 4))
      else $error("full blend share did not pass the pixel unchanged");

   a_zero_blend_gray: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (blend_ff == '0)
      |-> (rsp_tdata[CHANNEL_BITS +: CHANNEL_BITS] == rsp_tdata[CHANNEL_BITS-1:0])
          && (rsp_tdata[2*CHANNEL_BITS +: CHANNEL_BITS] == rsp_tdata[CHANNEL_BITS-1:0])
          || $past(csr_we, 1) || $past(csr_we, 2) || $past(csr_we, 3)
          || $past(csr_we, 4) || $past(csr_we, 5))
      else $error("zero blend share gave unequal colour channels");
`endif

endmodule
